// ===== rtl/kmcq_pkg.sv =====
// Shared types and constants for the key matrix change event queue.
`default_nettype none

package kmcq_pkg;

    // Matrix geometry: ten groups of eight keys.
    localparam int NUM_GROUPS = 10;
    localparam int GROUP_W    = 8;
    localparam int NUM_KEYS   = NUM_GROUPS * GROUP_W;

    // Widths of a key index and of a queued event code.
    localparam int KEY_W  = 7;
    localparam int CODE_W = KEY_W + 1;

    // Number of scans the front-to-back queue can hold.
    localparam int LINK_DEPTH = 2;

    // Per-key change masks of one scan, bit k is key k.
    typedef struct packed {
        logic [NUM_KEYS-1:0] released;
        logic [NUM_KEYS-1:0] pressed;
    } t_change;

endpackage

`default_nettype wire

// ===== rtl/kmcq_front.sv =====
// Front end: accepts scan snapshots and turns them into release and press masks.
`default_nettype none

module kmcq_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [kmcq_pkg::NUM_KEYS-1:0] i_snapshot,
    input  wire logic                          i_link_ready,
    output logic                               o_in_ready,
    output logic                               o_push,
    output kmcq_pkg::t_change                  o_change
);

    // Snapshot of the previous accepted scan.
    logic [kmcq_pkg::NUM_KEYS-1:0] r_prev;

    // An item is taken whenever the queue towards the back end has room.
    assign o_in_ready = i_link_ready;
    assign o_push     = i_in_valid && i_link_ready;

    // A key that was down and is now up is released; the opposite is a press.
    assign o_change.released = r_prev & ~i_snapshot;
    assign o_change.pressed  = i_snapshot & ~r_prev;

    // Keep the new snapshot for the next comparison.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (o_push) begin
            r_prev <= i_snapshot;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kmcq_link.sv =====
// Short queue of change masks between the front end and the back end.
`default_nettype none

module kmcq_link (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire kmcq_pkg::t_change  i_change,
    output logic                    o_ready,
    output logic                    o_valid,
    output kmcq_pkg::t_change       o_change,
    input  wire logic               i_pop
);

    localparam int PTR_W = $clog2(kmcq_pkg::LINK_DEPTH);
    localparam int CNT_W = $clog2(kmcq_pkg::LINK_DEPTH + 1);

    kmcq_pkg::t_change r_entry [kmcq_pkg::LINK_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    assign o_ready  = (r_count != CNT_W'(kmcq_pkg::LINK_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_change = r_entry[r_rd];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(kmcq_pkg::LINK_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rd <= (r_rd == PTR_W'(kmcq_pkg::LINK_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    // Entry storage; the pusher only pushes while there is room.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_change;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kmcq_back.sv =====
// Back end: walks the keys of one scan into the event FIFO, then pops one event.
`default_nettype none

module kmcq_back #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_link_valid,
    input  wire kmcq_pkg::t_change          i_change,
    output logic                            o_pop,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_event_valid,
    output logic [kmcq_pkg::KEY_W-1:0]      o_key_number,
    output logic                            o_is_release
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [kmcq_pkg::NUM_KEYS-1:0]  r_rel;
    logic [kmcq_pkg::NUM_KEYS-1:0]  r_prs;
    logic [kmcq_pkg::KEY_W-1:0]     r_key;
    logic [PTR_W-1:0]               r_wr_ptr;
    logic [PTR_W-1:0]               r_rd_ptr;
    logic [PTR_W-1:0]               wr_next;
    logic                           r_empty;
    logic [kmcq_pkg::CODE_W-1:0]    r_rd_data;
    logic [kmcq_pkg::CODE_W-1:0]    mem [FIFO_DEPTH];
    logic                           push_en;
    logic                           load_out;
    logic                           last_key;

    // Event FIFO write side: one key per cycle, dropped when the ring is full.
    assign wr_next  = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign push_en  = (r_state == ST_WALK) && (r_rel[0] || r_prs[0]) && (wr_next != r_rd_ptr);
    assign last_key = (r_key == kmcq_pkg::KEY_W'(kmcq_pkg::NUM_KEYS - 1));
    assign o_pop    = (r_state == ST_IDLE) && i_link_valid;
    assign load_out = (r_state == ST_DONE) && (!o_out_valid || i_out_ready);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_link_valid) n_state = ST_WALK;
            ST_WALK: if (last_key) n_state = ST_READ;
            ST_READ: n_state = ST_DONE;
            ST_DONE: if (load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers: state, pointers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push_en) begin
                r_wr_ptr <= wr_next;
            end
            if ((r_state == ST_READ) && (r_rd_ptr != r_wr_ptr)) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Walk registers: the masks shift down one key per cycle.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rel <= i_change.released;
            r_prs <= i_change.pressed;
            r_key <= '0;
        end else if (r_state == ST_WALK) begin
            r_rel <= r_rel >> 1;
            r_prs <= r_prs >> 1;
            r_key <= r_key + 1'b1;
        end
    end

    // Event storage, written during the walk and read once per item.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            mem[r_wr_ptr] <= {r_rel[0], r_key};
        end
        if (r_state == ST_READ) begin
            r_rd_data <= mem[r_rd_ptr];
            r_empty   <= (r_rd_ptr == r_wr_ptr);
        end
    end

    // Result payload; an empty queue gives all-zero fields.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_event_valid <= !r_empty;
            o_key_number  <= r_empty ? '0 : r_rd_data[kmcq_pkg::KEY_W-1:0];
            o_is_release  <= r_empty ? 1'b0 : r_rd_data[kmcq_pkg::CODE_W-1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/key_matrix_change_event_queue_core.sv =====
// Top level of the key matrix change event queue.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+--------------------------------------------
//  input   | i_in_valid / o_in_ready   | i_group0_keys .. i_group9_keys (8 bits each)
//  output  | o_out_valid / i_out_ready | o_event_valid, o_key_number, o_is_release
//
// Each item passes through the back end in order: a start step, the key walk
// (one key per cycle into the single-port event FIFO), one FIFO read, one load.
// The front end takes a new scan every cycle while the two-entry queue has room.
// Reset is synchronous and active low; it empties both queues and clears the
// stored snapshot. A stalled output holds the back end, the queue then fills and
// o_in_ready falls.
`default_nettype none

module key_matrix_change_event_queue_core #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [7:0]                  i_group0_keys,
    input  wire logic [7:0]                  i_group1_keys,
    input  wire logic [7:0]                  i_group2_keys,
    input  wire logic [7:0]                  i_group3_keys,
    input  wire logic [7:0]                  i_group4_keys,
    input  wire logic [7:0]                  i_group5_keys,
    input  wire logic [7:0]                  i_group6_keys,
    input  wire logic [7:0]                  i_group7_keys,
    input  wire logic [7:0]                  i_group8_keys,
    input  wire logic [7:0]                  i_group9_keys,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_event_valid,
    output logic [kmcq_pkg::KEY_W-1:0]       o_key_number,
    output logic                             o_is_release
);

    logic [kmcq_pkg::NUM_KEYS-1:0] snapshot;
    logic                          push;
    logic                          link_ready;
    logic                          link_valid;
    logic                          pop;
    kmcq_pkg::t_change             front_change;
    kmcq_pkg::t_change             head_change;

    // Key k sits at bit k of the flat snapshot.
    assign snapshot = {i_group9_keys, i_group8_keys, i_group7_keys, i_group6_keys,
                       i_group5_keys, i_group4_keys, i_group3_keys, i_group2_keys,
                       i_group1_keys, i_group0_keys};

    // Front end: compare with the previous scan.
    kmcq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_snapshot   (snapshot),
        .i_link_ready (link_ready),
        .o_in_ready   (o_in_ready),
        .o_push       (push),
        .o_change     (front_change)
    );

    // Queue of change masks.
    kmcq_link u_link (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_change (front_change),
        .o_ready  (link_ready),
        .o_valid  (link_valid),
        .o_change (head_change),
        .i_pop    (pop)
    );

    // Back end: event FIFO and result register.
    kmcq_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_link_valid  (link_valid),
        .i_change      (head_change),
        .o_pop         (pop),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_event_valid (o_event_valid),
        .o_key_number  (o_key_number),
        .o_is_release  (o_is_release)
    );

endmodule

`default_nettype wire

// ===== rtl/kmcq_checker.sv =====
// Port-level checks for the key matrix change event queue, bound to the top level.
`default_nettype none

module kmcq_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic                        o_event_valid,
    input wire logic [kmcq_pkg::KEY_W-1:0]  o_key_number,
    input wire logic                        o_is_release
);

    // A result waiting to be taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    // Its payload does not change while it waits.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
        $stable(o_event_valid) && $stable(o_key_number) && $stable(o_is_release))
        else $error("stalled result changed");

    // An empty-queue report carries zero fields.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_event_valid |-> (o_key_number == '0) && !o_is_release)
        else $error("empty report with non-zero fields");

    // A popped event names a key of the matrix.
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_valid |->
        (o_key_number < kmcq_pkg::KEY_W'(kmcq_pkg::NUM_KEYS)))
        else $error("event key number outside the matrix");

    // Nothing is offered straight after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind key_matrix_change_event_queue_core kmcq_checker u_kmcq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_event_valid (o_event_valid),
    .o_key_number  (o_key_number),
    .o_is_release  (o_is_release)
);

`default_nettype wire
